// ----- rtl/rwf_pkg.sv -----
// ----------------------------------------------------------------------------
// rwf_pkg: shared constants and types of the RGB window filter
// Sizes, field widths, register and command codes, pipeline step record.
// ----------------------------------------------------------------------------
package rwf_pkg;

	localparam int MAX_W      = 2048;
	localparam int K          = 5;
	localparam int CH         = 3;
	localparam int ROW_LIMIT  = 2048;
	localparam int BANK_COLS  = (MAX_W + K - 1) / K;
	localparam int BANK_DEPTH = K * BANK_COLS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int CQ_W       = $clog2(BANK_COLS + 1);
	localparam int MOD_W      = (K > 1) ? $clog2(K) : 1;
	localparam int NCOEF      = K * K;
	localparam int CIDX_W     = 5;
	localparam int POS_W      = 11;
	localparam int SIZE_W     = 12;
	localparam int KSZ_W      = 3;
	localparam int PIX_W      = 8;
	localparam int COEF_W     = 16;
	localparam int PROD_W     = COEF_W + PIX_W;
	localparam int SUM_W      = 29;
	localparam int CFG_IDX_W  = 3;

	localparam logic CMD_COEF  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMG_W = 3'd0,
		REG_IMG_H = 3'd1,
		REG_KER_W = 3'd2,
		REG_KER_H = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	typedef logic [CH-1:0][PIX_W-1:0] rgb_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	typedef struct packed {
		logic             first;
		logic             last_row;
		logic             run_last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} step_t;

endpackage

// ----- rtl/rwf_if.sv -----
// ----------------------------------------------------------------------------
// rwf_if: stream channels of the RGB window filter
// Input item channel and result item channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwf_in_if import rwf_pkg::*;;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [CIDX_W-1:0]  coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic [PIX_W-1:0]   red_in;
	logic [PIX_W-1:0]   green_in;
	logic [PIX_W-1:0]   blue_in;

	modport source (output valid, cmd, coef_index, coef_value, red_in, green_in, blue_in,
		input ready);
	modport sink (input valid, cmd, coef_index, coef_value, red_in, green_in, blue_in,
		output ready);
endinterface

interface rwf_out_if import rwf_pkg::*;;
	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  out_row;
	logic [POS_W-1:0]  out_column;
	logic signed [SUM_W-1:0] red_sum;
	logic signed [SUM_W-1:0] green_sum;
	logic signed [SUM_W-1:0] blue_sum;
	logic              run_last;

	modport source (output valid, out_row, out_column, red_sum, green_sum, blue_sum,
		run_last, input ready);
	modport sink (input valid, out_row, out_column, red_sum, green_sum, blue_sum,
		run_last, output ready);
endinterface

// ----- rtl/rwf_line_banks.sv -----
// ----------------------------------------------------------------------------
// rwf_line_banks: column-interleaved line store
// One bank per window column; column w lives in bank w mod K, so any K
// consecutive columns are read in the same cycle, one from each bank.
// ----------------------------------------------------------------------------
module rwf_line_banks import rwf_pkg::*; (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [MOD_W-1:0]              wr_bank,
	input  logic [BANK_AW-1:0]            wr_addr,
	input  rgb_t                          wr_data,
	input  logic                          rd_en,
	input  logic [K-1:0][BANK_AW-1:0]     rd_addr,
	output rgb_t [K-1:0]                  rd_data
);

	for (genvar b = 0; b < K; b++) begin : g_bank
		rgb_t mem [BANK_DEPTH];

		// write the new pixel, read one entry per step
		always_ff @(posedge clk) begin
			if (wr_en && (wr_bank == MOD_W'(b))) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_data[b] <= mem[rd_addr[b]];
			end
		end
	end

endmodule

// ----- rtl/rwf_lane.sv -----
// ----------------------------------------------------------------------------
// rwf_lane: one window-column lane
// Multiplies one coefficient by the three color samples of one pixel.
// ----------------------------------------------------------------------------
module rwf_lane import rwf_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  coef_t coef,
	input  rgb_t  pix,
	output prod_t prod [CH]
);

	logic signed [PROD_W:0] full [CH];

	// signed coefficient times unsigned sample
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			full[c] = coef * $signed({1'b0, pix[c]});
		end
	end

	// register the products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < CH; c++) begin
				prod[c] <= full[c][PROD_W-1:0];
			end
		end
	end

endmodule

// ----- rtl/rwf_merge.sv -----
// ----------------------------------------------------------------------------
// rwf_merge: lane merge, row accumulation and result register
// Adds the lane products, accumulates window rows, holds the result.
// ----------------------------------------------------------------------------
module rwf_merge import rwf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s2_valid,
	input  step_t         s2_step,
	input  prod_t         prod [K][CH],
	output logic          adv,
	rwf_out_if.source     out_chan
);

	sum_t             lane_sum [CH];
	sum_t             acc_next [CH];
	sum_t             acc_q    [CH];
	sum_t             res_q    [CH];
	logic             out_valid_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;
	logic             run_last_q;
	logic             emit;

	// stall the pipe while a finished result cannot be placed
	assign adv  = !(s2_valid && s2_step.last_row && out_valid_q && !out_chan.ready);
	assign emit = adv && s2_valid && s2_step.last_row;

	// sum across lanes, then add the running row total
	always_comb begin
		for (int c = 0; c < CH; c++) begin
			lane_sum[c] = '0;
			for (int l = 0; l < K; l++) begin
				lane_sum[c] = lane_sum[c] + SUM_W'(prod[l][c]);
			end
			acc_next[c] = (s2_step.first ? sum_t'(0) : acc_q[c]) + lane_sum[c];
		end
	end

	// accumulate rows
	always_ff @(posedge clk) begin
		if (adv && s2_valid) begin
			acc_q <= acc_next;
		end
	end

	// hold the result until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q      <= acc_next;
			row_q      <= s2_step.row;
			col_q      <= s2_step.col;
			run_last_q <= s2_step.run_last;
		end
	end

	assign out_chan.valid      = out_valid_q;
	assign out_chan.out_row    = row_q;
	assign out_chan.out_column = col_q;
	assign out_chan.red_sum    = res_q[0];
	assign out_chan.green_sum  = res_q[1];
	assign out_chan.blue_sum   = res_q[2];
	assign out_chan.run_last   = run_last_q;

endmodule

// ----- rtl/rgb_window_filter_2d_core.sv -----
// ----------------------------------------------------------------------------
// rgb_window_filter_2d_core: anchored 2D window filter over an RGB stream
// Sequencer, line store, five multiplier lanes and the merge stage.
// ----------------------------------------------------------------------------
// in_chan carries coefficient loads (cmd 0) and pixels (cmd 1) in raster
// order; out_chan carries one filtered position per transfer, run_last
// marking the final result caused by a pixel. The cfg port (cfg_we,
// cfg_index, cfg_data) sets image and window sizes and restarts the frame.
// A coefficient load or a pixel that completes no window is taken while
// idle with stage 0 empty, so such items stream at one per cycle. A pixel
// that completes windows starts a run over every completed output (up to
// kernel_height rows per output, up to 25 outputs at a frame corner); the
// five lanes take one window row per cycle from the banked line store while
// the pipeline is not stalled, and the input reopens once the last row has
// left the first stage. Results pass stages 0 to 2 into the result register.
// Reset clears the coefficients to zero, the counters and the sizes to
// 640 x 480 with a 3 x 3 window; the line store is not cleared. When the
// receiver stalls, one result waits in the output register and the
// pipeline holds behind it.
// ----------------------------------------------------------------------------
module rgb_window_filter_2d_core import rwf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [SIZE_W-1:0]     cfg_data,
	rwf_in_if.sink                in_chan,
	rwf_out_if.source             out_chan
);

	seq_state_t        state_q;
	logic [SIZE_W-1:0] img_w_q, img_h_q;
	logic [KSZ_W-1:0]  ker_w_q, ker_h_q;
	coef_t             coef_q [NCOEF];

	logic [POS_W-1:0]  row_q, col_q;
	logic [MOD_W-1:0]  rmod_q, cr_q;
	logic [CQ_W-1:0]   cq_q;

	logic [POS_W-1:0]  i_q, ihi_q, j_q, jlo_q, jhi_q, h_q;
	logic [MOD_W-1:0]  imod_q, jr_q, jlor_q, hmod_q;
	logic [CQ_W-1:0]   jq_q, jloq_q;
	logic [KSZ_W-1:0]  dh_q;

	logic [SIZE_W-1:0] w_eff, h_eff;
	logic [KSZ_W-1:0]  kw_eff, kh_eff;

	logic adv;
	logic acc_pix, acc_coef;
	logic s0_valid, s1_valid, s2_valid;

	// clamp size registers
	always_comb begin
		w_eff  = (img_w_q == '0) ? SIZE_W'(1) :
			(img_w_q > SIZE_W'(MAX_W)) ? SIZE_W'(MAX_W) : img_w_q;
		h_eff  = (img_h_q == '0) ? SIZE_W'(1) :
			(img_h_q > SIZE_W'(ROW_LIMIT)) ? SIZE_W'(ROW_LIMIT) : img_h_q;
		kw_eff = (ker_w_q == '0) ? KSZ_W'(1) :
			(ker_w_q > KSZ_W'(K)) ? KSZ_W'(K) : ker_w_q;
		kh_eff = (ker_h_q == '0) ? KSZ_W'(1) :
			(ker_h_q > KSZ_W'(K)) ? KSZ_W'(K) : ker_h_q;
	end

	assign in_chan.ready = (state_q == ST_IDLE) && !s0_valid;
	assign acc_pix  = in_chan.valid && in_chan.ready && (in_chan.cmd == CMD_PIXEL);
	assign acc_coef = in_chan.valid && in_chan.ready && (in_chan.cmd == CMD_COEF);

	// anchor ranges of the incoming pixel
	logic             r_last, c_last, r_ok, c_ok;
	logic [KSZ_W-1:0] d_r, d_c;
	logic [POS_W-1:0] ilo, jlo;
	logic [MOD_W-1:0] imod_lo, jr_lo;
	logic [CQ_W-1:0]  jq_lo;

	always_comb begin
		r_last = ({1'b0, row_q} == h_eff - SIZE_W'(1));
		c_last = ({1'b0, col_q} == w_eff - SIZE_W'(1));
		r_ok   = r_last || (row_q >= POS_W'(kh_eff) - POS_W'(1));
		c_ok   = c_last || (col_q >= POS_W'(kw_eff) - POS_W'(1));
		d_r    = (row_q < POS_W'(kh_eff) - POS_W'(1)) ? row_q[KSZ_W-1:0] :
			kh_eff - KSZ_W'(1);
		d_c    = (col_q < POS_W'(kw_eff) - POS_W'(1)) ? col_q[KSZ_W-1:0] :
			kw_eff - KSZ_W'(1);
		ilo    = row_q - POS_W'(d_r);
		jlo    = col_q - POS_W'(d_c);
		imod_lo = (rmod_q >= MOD_W'(d_r)) ? rmod_q - MOD_W'(d_r) :
			rmod_q + MOD_W'(K) - MOD_W'(d_r);
		if (cr_q >= MOD_W'(d_c)) begin
			jr_lo = cr_q - MOD_W'(d_c);
			jq_lo = cq_q;
		end else begin
			jr_lo = cr_q + MOD_W'(K) - MOD_W'(d_c);
			jq_lo = cq_q - CQ_W'(1);
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= SIZE_W'(640);
			img_h_q <= SIZE_W'(480);
			ker_w_q <= KSZ_W'(3);
			ker_h_q <= KSZ_W'(3);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMG_W: img_w_q <= cfg_data;
				REG_IMG_H: img_h_q <= cfg_data;
				REG_KER_W: ker_w_q <= cfg_data[KSZ_W-1:0];
				REG_KER_H: ker_h_q <= cfg_data[KSZ_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficient table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < NCOEF; n++) begin
				coef_q[n] <= '0;
			end
		end else if (acc_coef && (in_chan.coef_index < CIDX_W'(NCOEF))) begin
			coef_q[in_chan.coef_index] <= in_chan.coef_value;
		end
	end

	// raster position counters
	logic cfg_hit;
	assign cfg_hit = cfg_we && (cfg_index <= CFG_IDX_W'(REG_KER_H));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			rmod_q <= '0;
			col_q  <= '0;
			cq_q   <= '0;
			cr_q   <= '0;
		end else if (cfg_hit) begin
			row_q  <= '0;
			rmod_q <= '0;
			col_q  <= '0;
			cq_q   <= '0;
			cr_q   <= '0;
		end else if (acc_pix) begin
			if (c_last) begin
				col_q <= '0;
				cq_q  <= '0;
				cr_q  <= '0;
				if (r_last) begin
					row_q  <= '0;
					rmod_q <= '0;
				end else begin
					row_q  <= row_q + POS_W'(1);
					rmod_q <= (rmod_q == MOD_W'(K - 1)) ? '0 : rmod_q + MOD_W'(1);
				end
			end else begin
				col_q <= col_q + POS_W'(1);
				if (cr_q == MOD_W'(K - 1)) begin
					cr_q <= '0;
					cq_q <= cq_q + CQ_W'(1);
				end else begin
					cr_q <= cr_q + MOD_W'(1);
				end
			end
		end
	end

	// step issued by the sequencer
	logic                      last_row, run_last;
	logic [K-1:0][BANK_AW-1:0] addr_c;
	logic [K-1:0]              mask_c;

	always_comb begin
		logic [CQ_W-1:0]  q;
		last_row = (dh_q == kh_eff - KSZ_W'(1)) || ({1'b0, h_q} == h_eff - SIZE_W'(1));
		run_last = (i_q == ihi_q) && (j_q == jhi_q);
		for (int b = 0; b < K; b++) begin
			if (MOD_W'(b) >= jr_q) begin
				q = jq_q;
			end else begin
				q = jq_q + CQ_W'(1);
			end
			addr_c[b] = BANK_AW'(hmod_q) * BANK_AW'(BANK_COLS) + BANK_AW'(q);
		end
		for (int n = 0; n < K; n++) begin
			mask_c[n] = (KSZ_W'(n) < kw_eff) &&
				(({1'b0, j_q} + SIZE_W'(n)) < w_eff);
		end
	end

	// sequencer: outputs in raster order, one window row per cycle unless the pipeline stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_pix && r_ok && c_ok) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv && last_row && run_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (acc_pix) begin
				i_q    <= ilo;
				imod_q <= imod_lo;
				ihi_q  <= r_last ? row_q : ilo;
				h_q    <= ilo;
				hmod_q <= imod_lo;
				dh_q   <= '0;
				j_q    <= jlo;
				jq_q   <= jq_lo;
				jr_q   <= jr_lo;
				jlo_q  <= jlo;
				jloq_q <= jq_lo;
				jlor_q <= jr_lo;
				jhi_q  <= c_last ? col_q : jlo;
			end
		end else if (adv) begin
			if (!last_row) begin
				dh_q   <= dh_q + KSZ_W'(1);
				h_q    <= h_q + POS_W'(1);
				hmod_q <= (hmod_q == MOD_W'(K - 1)) ? '0 : hmod_q + MOD_W'(1);
			end else begin
				dh_q <= '0;
				if (j_q != jhi_q) begin
					j_q    <= j_q + POS_W'(1);
					h_q    <= i_q;
					hmod_q <= imod_q;
					if (jr_q == MOD_W'(K - 1)) begin
						jr_q <= '0;
						jq_q <= jq_q + CQ_W'(1);
					end else begin
						jr_q <= jr_q + MOD_W'(1);
					end
				end else begin
					i_q    <= i_q + POS_W'(1);
					h_q    <= i_q + POS_W'(1);
					imod_q <= (imod_q == MOD_W'(K - 1)) ? '0 : imod_q + MOD_W'(1);
					hmod_q <= (imod_q == MOD_W'(K - 1)) ? '0 : imod_q + MOD_W'(1);
					j_q    <= jlo_q;
					jq_q   <= jloq_q;
					jr_q   <= jlor_q;
				end
			end
		end
	end

	// stage 0: addresses and step record
	step_t                     s0_step, s1_step, s2_step;
	logic [K-1:0][BANK_AW-1:0] s0_addr;
	logic [K-1:0]              s0_mask, s1_mask;
	logic [MOD_W-1:0]          s0_jr, s1_jr;
	logic [KSZ_W-1:0]          s0_dh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s0_valid <= 1'b0;
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else if (adv) begin
			s0_valid <= (state_q == ST_RUN);
			s1_valid <= s0_valid;
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s0_step.first    <= (dh_q == '0);
			s0_step.last_row <= last_row;
			s0_step.run_last <= run_last;
			s0_step.row      <= i_q;
			s0_step.col      <= j_q;
			s0_addr          <= addr_c;
			s0_mask          <= mask_c;
			s0_jr            <= jr_q;
			s0_dh            <= dh_q;
			s1_step          <= s0_step;
			s1_mask          <= s0_mask;
			s1_jr            <= s0_jr;
			s2_step          <= s1_step;
		end
	end

	// line store
	rgb_t [K-1:0]     bank_rd;
	logic [BANK_AW-1:0] wr_addr;
	rgb_t             wr_pix;

	assign wr_addr = BANK_AW'(rmod_q) * BANK_AW'(BANK_COLS) + BANK_AW'(cq_q);
	assign wr_pix  = {in_chan.blue_in, in_chan.green_in, in_chan.red_in};

	rwf_line_banks u_banks (
		.clk     (clk),
		.wr_en   (acc_pix),
		.wr_bank (cr_q),
		.wr_addr (wr_addr),
		.wr_data (wr_pix),
		.rd_en   (adv),
		.rd_addr (s0_addr),
		.rd_data (bank_rd)
	);

	// stage 1: coefficients of the window row
	coef_t coef_s1 [K];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 0; n < K; n++) begin
				coef_s1[n] <= s0_mask[n] ?
					coef_q[CIDX_W'(s0_dh) * CIDX_W'(K) + CIDX_W'(n)] : coef_t'(0);
			end
		end
	end

	// rotate bank data into lane order, drop lanes past the window or image
	rgb_t lane_pix [K];

	always_comb begin
		logic [MOD_W:0] sel;
		for (int n = 0; n < K; n++) begin
			sel = {1'b0, s1_jr} + (MOD_W + 1)'(n);
			if (sel >= (MOD_W + 1)'(K)) begin
				sel = sel - (MOD_W + 1)'(K);
			end
			lane_pix[n] = s1_mask[n] ? bank_rd[sel[MOD_W-1:0]] : rgb_t'(0);
		end
	end

	// stage 2: lane products
	prod_t prod [K][CH];

	for (genvar n = 0; n < K; n++) begin : g_lane
		rwf_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.coef (coef_s1[n]),
			.pix  (lane_pix[n]),
			.prod (prod[n])
		);
	end

	// stage 3: merge and result register
	rwf_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2_step  (s2_step),
		.prod     (prod),
		.adv      (adv),
		.out_chan (out_chan)
	);

endmodule
